// ===== rtl/smsm_pkg.sv =====
`default_nettype none
package smsm_pkg;
    localparam int SCORE_W        = 16;
    localparam int COUNT_W        = 9;
    localparam int STAT_W         = 16;
    localparam int DEF_MAX_ITEMS  = 256;
    localparam int DEF_SCORE_BITS = 16;
endpackage
`default_nettype wire

// ===== rtl/set_mean_stddev_median.sv =====
// Set statistics: count, mean, population standard deviation and median.
// Input channel (i_in_valid / o_in_stall): one score per item, i_last closes
// the set. Scores load at one item per cycle into an internal memory while
// the running sum and sum of squares advance. Scores beyond MAX_ITEMS are
// dropped and flag o_overflowed; a dropped last item still closes the set.
// After the last item the input stalls while the block computes, in order:
//   1 + CW serial multiply steps (CW = bits of the count), SW steps for the
//   square of the sum (SW = SCORE_BITS + CW), two serial divisions, SW
//   square root steps, a median search that scans the whole set once per
//   candidate read from the score memory, which has one read port, and a
//   hand-off of the result to the output register.
// The median search dominates larger sets.
// Output channel (o_out_valid / i_out_stall): one result per set, held in an
// output register; a new set loads while that result waits. If the receiver
// still stalls when the next result is ready, the block holds that result
// and stalls the input. Reset empties the set and drops any pending result.
`default_nettype none
module set_mean_stddev_median #(
    parameter int MAX_ITEMS  = smsm_pkg::DEF_MAX_ITEMS,
    parameter int SCORE_BITS = smsm_pkg::DEF_SCORE_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [smsm_pkg::SCORE_W-1:0]  i_score,
    input  wire logic                          i_last,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [smsm_pkg::COUNT_W-1:0]       o_item_count,
    output logic [smsm_pkg::STAT_W-1:0]        o_mean,
    output logic [smsm_pkg::STAT_W-1:0]        o_std_dev,
    output logic [smsm_pkg::STAT_W-1:0]        o_median,
    output logic                               o_overflowed
);
    import smsm_pkg::*;

    localparam int SB     = SCORE_BITS;
    localparam int CW     = $clog2(MAX_ITEMS + 1);
    localparam int AW     = $clog2(MAX_ITEMS);
    localparam int SW     = SB + CW;
    localparam int QW     = 2 * SB + CW;
    localparam int PW     = 2 * SW;
    localparam int DW     = 2 * CW;
    localparam int RW     = SW;
    localparam int STW    = $clog2(SW + 1);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_SETUP = 4'd1;
    localparam logic [3:0] S_MULA  = 4'd2;
    localparam logic [3:0] S_MULB  = 4'd3;
    localparam logic [3:0] S_DMGO  = 4'd4;
    localparam logic [3:0] S_DMW   = 4'd5;
    localparam logic [3:0] S_DVGO  = 4'd6;
    localparam logic [3:0] S_DVW   = 4'd7;
    localparam logic [3:0] S_SQRT  = 4'd8;
    localparam logic [3:0] S_MCAND = 4'd9;
    localparam logic [3:0] S_MLOAD = 4'd10;
    localparam logic [3:0] S_MSCAN = 4'd11;
    localparam logic [3:0] S_MCHK  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [SB-1:0] mem [MAX_ITEMS];
    logic [SB-1:0] r_rdata;
    logic [AW-1:0] rd_addr;

    logic [3:0]    r_state;
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_sum;
    logic [QW-1:0] r_sumsq;
    logic          r_drop;

    logic [PW-1:0]  r_mc;
    logic [SW-1:0]  r_mp;
    logic [PW-1:0]  r_acc;
    logic [PW-1:0]  n_acc;
    logic [PW-1:0]  r_prod1;
    logic [DW-1:0]  r_nn;
    logic [STW-1:0] r_step;

    logic          div_start;
    logic [PW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic          div_busy;
    logic [PW-1:0] div_quot;

    logic [PW-1:0]  r_mean;
    logic [PW-1:0]  r_sqv;
    logic [RW-1:0]  r_root;
    logic [RW:0]    r_srem;
    logic [RW+1:0]  sq_sh;
    logic [RW+1:0]  sq_trial;
    logic           sq_ge;

    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [SB-1:0] r_cand;
    logic [CW-1:0] r_lt;
    logic [CW-1:0] r_le;
    logic [SB-1:0] r_lo;
    logic [SB-1:0] r_hi;
    logic          r_flo;
    logic          r_fhi;
    logic [CW-1:0] k_lo;
    logic [CW-1:0] k_hi;
    logic          hit_lo;
    logic          hit_hi;

    logic          r_out_valid;
    logic [COUNT_W-1:0] r_o_count;
    logic [STAT_W-1:0]  r_o_mean;
    logic [STAT_W-1:0]  r_o_sd;
    logic [STAT_W-1:0]  r_o_med;
    logic               r_o_ovf;

    logic          in_acc;
    logic          keep;
    logic [SB-1:0] s_in;
    logic          out_free;

    assign s_in     = SB'(i_score);
    assign in_acc   = i_in_valid && (r_state == S_LOAD);
    assign keep     = r_count < CW'(MAX_ITEMS);
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_LOAD);

    assign n_acc = r_mp[0] ? r_acc + r_mc : r_acc;

    assign k_lo   = (r_count - 1'b1) >> 1;
    assign k_hi   = r_count >> 1;
    assign hit_lo = (r_lt <= k_lo) && (k_lo < r_le);
    assign hit_hi = (r_lt <= k_hi) && (k_hi < r_le);

    always_comb begin
        sq_sh    = {r_srem[RW-1:0], r_sqv[PW-1:PW-2]};
        sq_trial = {r_root, 2'b01};
        sq_ge    = sq_sh >= sq_trial;
    end

    always_comb begin
        div_start = (r_state == S_DMGO) || (r_state == S_DVGO);
        if (r_state == S_DMGO) begin
            div_num = PW'(r_sum);
            div_den = DW'(r_count);
        end else begin
            div_num = (r_prod1 >= r_acc) ? r_prod1 - r_acc : '0;
            div_den = r_nn;
        end
    end

    smsm_div #(
        .NUM_W(PW),
        .DEN_W(DW)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_busy (div_busy),
        .o_quot (div_quot)
    );

    always_comb begin
        case (r_state)
            S_MCAND: rd_addr = r_i[AW-1:0];
            S_MSCAN: rd_addr = AW'(r_j + 1'b1);
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && keep) begin
            mem[r_count[AW-1:0]] <= s_in;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (keep) begin
                            r_count <= r_count + 1'b1;
                            r_sum   <= r_sum + SW'(s_in);
                            r_sumsq <= r_sumsq + QW'(s_in) * QW'(s_in);
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_last) begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: r_state <= S_MULA;
                S_MULA: begin
                    if (r_step == STW'(CW - 1)) begin
                        r_state <= S_MULB;
                    end
                end
                S_MULB: begin
                    if (r_step == STW'(SW - 1)) begin
                        r_state <= S_DMGO;
                    end
                end
                S_DMGO: r_state <= S_DMW;
                S_DMW: begin
                    if (!div_busy) begin
                        r_state <= S_DVGO;
                    end
                end
                S_DVGO: r_state <= S_DVW;
                S_DVW: begin
                    if (!div_busy) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_step == STW'(RW - 1)) begin
                        r_state <= S_MCAND;
                    end
                end
                S_MCAND: r_state <= S_MLOAD;
                S_MLOAD: r_state <= S_MSCAN;
                S_MSCAN: begin
                    if (r_j == r_count - 1'b1) begin
                        r_state <= S_MCHK;
                    end
                end
                S_MCHK: begin
                    if ((r_flo || hit_lo) && (r_fhi || hit_hi)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_MCAND;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_count     <= '0;
                        r_sum       <= '0;
                        r_sumsq     <= '0;
                        r_drop      <= 1'b0;
                        r_state     <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_SETUP: begin
                r_mc   <= PW'(r_sumsq);
                r_mp   <= SW'(r_count);
                r_acc  <= '0;
                r_step <= '0;
                r_nn   <= DW'(r_count) * DW'(r_count);
            end
            S_MULA: begin
                if (r_step == STW'(CW - 1)) begin
                    r_prod1 <= n_acc;
                    r_mc    <= PW'(r_sum);
                    r_mp    <= r_sum;
                    r_acc   <= '0;
                    r_step  <= '0;
                end else begin
                    r_acc  <= n_acc;
                    r_mc   <= r_mc << 1;
                    r_mp   <= r_mp >> 1;
                    r_step <= r_step + 1'b1;
                end
            end
            S_MULB: begin
                r_acc  <= n_acc;
                r_mc   <= r_mc << 1;
                r_mp   <= r_mp >> 1;
                r_step <= r_step + 1'b1;
            end
            S_DMW: begin
                if (!div_busy) begin
                    r_mean <= div_quot;
                end
            end
            S_DVW: begin
                if (!div_busy) begin
                    r_sqv  <= div_quot;
                    r_root <= '0;
                    r_srem <= '0;
                    r_step <= '0;
                end
            end
            S_SQRT: begin
                r_sqv  <= r_sqv << 2;
                r_step <= r_step + 1'b1;
                if (sq_ge) begin
                    r_srem <= (RW + 1)'(sq_sh - sq_trial);
                    r_root <= {r_root[RW-2:0], 1'b1};
                end else begin
                    r_srem <= sq_sh[RW:0];
                    r_root <= {r_root[RW-2:0], 1'b0};
                end
                if (r_step == STW'(RW - 1)) begin
                    r_i   <= '0;
                    r_flo <= 1'b0;
                    r_fhi <= 1'b0;
                end
            end
            S_MLOAD: begin
                r_cand <= r_rdata;
                r_j    <= '0;
                r_lt   <= '0;
                r_le   <= '0;
            end
            S_MSCAN: begin
                r_j <= r_j + 1'b1;
                if (r_rdata < r_cand) begin
                    r_lt <= r_lt + 1'b1;
                end
                if (r_rdata <= r_cand) begin
                    r_le <= r_le + 1'b1;
                end
            end
            S_MCHK: begin
                r_i <= r_i + 1'b1;
                if (!r_flo && hit_lo) begin
                    r_lo  <= r_cand;
                    r_flo <= 1'b1;
                end
                if (!r_fhi && hit_hi) begin
                    r_hi  <= r_cand;
                    r_fhi <= 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    logic [SB:0] med_sum;
    logic [SB-1:0] med_lo;
    logic [SB-1:0] med_hi;

    always_comb begin
        med_lo  = r_lo;
        med_hi  = r_hi;
        med_sum = {1'b0, med_lo} + {1'b0, med_hi};
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_count <= COUNT_W'(r_count);
            r_o_mean  <= STAT_W'(r_mean);
            r_o_sd    <= STAT_W'(r_root);
            r_o_med   <= STAT_W'(med_sum >> 1);
            r_o_ovf   <= r_drop;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_item_count = r_o_count;
    assign o_mean       = r_o_mean;
    assign o_std_dev    = r_o_sd;
    assign o_median     = r_o_med;
    assign o_overflowed = r_o_ovf;
endmodule
`default_nettype wire

// ===== rtl/smsm_div.sv =====
`default_nettype none
module smsm_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 18
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic [NUM_W-1:0]      o_quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        rem_sh = {r_rem, r_num[NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        if (ge) begin
            n_rem = DEN_W'(rem_sh - {1'b0, r_den});
        end else begin
            n_rem = rem_sh[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CW'(NUM_W - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= {r_num[NUM_W-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_num;
endmodule
`default_nettype wire
